>>> sv/stip_pkg.sv
// -----------------------------------------------------------------------------
// stip_pkg: shared constants and helpers for the text-to-integer parser
// Character codes, limits, register indexes and the digit decoder.
// -----------------------------------------------------------------------------
`default_nettype none

package stip_pkg;

   localparam int MAX_LEN   = 4096;
   localparam int POS_W     = $clog2(MAX_LEN + 1);
   localparam int VALUE_W   = 64;
   localparam int RADIX_W   = 6;
   localparam int CHAR_W    = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIX       = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNED_MODE = 1'd1;

   localparam logic [RADIX_W-1:0] RADIX_AUTO    = 6'd0;
   localparam logic [RADIX_W-1:0] RADIX_OCT     = 6'd8;
   localparam logic [RADIX_W-1:0] RADIX_DEC     = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_HEX     = 6'd16;
   localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
   localparam logic [RADIX_W-1:0] DIGIT_NONE    = 6'd36;
   localparam logic [RADIX_W-1:0] RESET_RADIX   = RADIX_DEC;

   localparam logic [VALUE_W-1:0] SIGNED_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] SIGNED_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic [VALUE_W-1:0] UNSIGNED_MAX = {VALUE_W{1'b1}};

   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
   localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
   localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
   localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;

   // Map a character to its digit value 0..35, or DIGIT_NONE.
   function automatic logic [RADIX_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
      logic [RADIX_W-1:0] d;
      d = DIGIT_NONE;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = RADIX_W'(c - CH_ZERO);
      end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
         d = RADIX_W'(c - CH_LO_A) + RADIX_DEC;
      end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
         d = RADIX_W'(c - CH_UP_A) + RADIX_DEC;
      end
      return d;
   endfunction

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
             (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
   endfunction

endpackage

`default_nettype wire

>>> sv/string_to_integer_parser.sv
// -----------------------------------------------------------------------------
// string_to_integer_parser: streaming strtol/strtoul style integer parser
// One character per transaction; the transaction marked last yields one result.
// -----------------------------------------------------------------------------
// Throughput: one character per cycle, except that a last character stalls while an
//   unread result waits; the multiply-add of the accumulator by the base and its range compare are combinational.
// Latency: the result of a string is valid the cycle after its last character.
// Reset: synchronous, active high; radix returns to 10, signed mode to 1,
//   the parse state to leading whitespace and the result register to empty.
`default_nettype none

module string_to_integer_parser (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write,
   input  wire logic [stip_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [stip_pkg::RADIX_W-1:0]    csr_wdata,
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic [stip_pkg::CHAR_W-1:0]     req_char_code,
   input  wire logic                            req_last_char,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic [stip_pkg::VALUE_W-1:0]    rsp_parsed_value,
   output      logic [stip_pkg::POS_W-1:0]      rsp_consumed_count,
   output      logic                            rsp_digits_seen,
   output      logic                            rsp_range_error
);
   import stip_pkg::*;

   localparam int PROD_W = VALUE_W + RADIX_W;
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LEN);

   typedef enum logic [2:0] {
      PH_SPACE,
      PH_SIGNED,
      PH_ZERO,
      PH_XSEEN,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   // Configuration registers
   logic [RADIX_W-1:0] radix_ff;
   logic               signed_mode_ff;

   // Parse state
   phase_type          phase_ff,   phase_in;
   logic [VALUE_W-1:0] acc_ff,     acc_in;
   logic               neg_ff,     neg_in;
   logic               any_ff,     any_in;
   logic               ovf_ff,     ovf_in;
   logic [RADIX_W-1:0] eff_ff,     eff_in;
   logic [POS_W-1:0]   pos_ff,     pos_in;
   logic [POS_W-1:0]   end_ff,     end_in;

   // Result register
   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               negate_ff;
   logic [POS_W-1:0]   count_ff;
   logic               digits_ff;
   logic               range_ff;

   logic               req_accept;
   logic               rsp_accept;
   logic [RADIX_W-1:0] digit;
   logic [RADIX_W-1:0] start_radix;
   logic [RADIX_W-1:0] take_radix;
   logic               try_take;
   logic               digit_ok;
   logic               took;
   logic               zero_prefix;
   logic [PROD_W-1:0]  prod;
   logic [PROD_W-1:0]  limit;
   logic               step_ovf;
   logic [POS_W-1:0]   next_pos;
   logic [VALUE_W-1:0] value_in;
   logic               negate_in;

   // Hold a last character back only while an unread result is still waiting.
   assign req_stall  = rsp_valid_ff & rsp_stall & req_last_char;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_accept = rsp_valid_ff & ~rsp_stall;

   assign digit       = digit_of(req_char_code);
   assign zero_prefix = ((radix_ff == RADIX_AUTO) || (radix_ff == RADIX_HEX)) &&
                        (req_char_code == CH_ZERO);
   // Automatic base: a leading zero means octal, anything else decimal.
   assign start_radix = (radix_ff != RADIX_AUTO) ? radix_ff :
                        (req_char_code == CH_ZERO) ? RADIX_OCT : RADIX_DEC;

   // Pick the base of this character's digit test and whether to try it.
   always_comb begin
      take_radix = eff_ff;
      try_take   = 1'b0;
      unique case (phase_ff)
         PH_SPACE: begin
            take_radix = start_radix;
            try_take   = ~is_space(req_char_code) &&
                         (req_char_code != CH_PLUS) && (req_char_code != CH_MINUS);
         end
         PH_SIGNED: begin
            take_radix = start_radix;
            try_take   = 1'b1;
         end
         PH_ZERO: begin
            try_take = (req_char_code != CH_LO_X) && (req_char_code != CH_UP_X);
         end
         PH_XSEEN: begin
            take_radix = RADIX_HEX;
            try_take   = 1'b1;
         end
         PH_DIGITS: begin
            try_take = 1'b1;
         end
         default: begin
            try_take = 1'b0;
         end
      endcase
   end

   // A base outside 2..36 never takes a digit, which also covers a bad radix.
   assign digit_ok = (take_radix >= RADIX_MIN) && (take_radix <= RADIX_MAX) &&
                     (digit < take_radix);
   assign took     = try_take & digit_ok;

   // acc * base + digit exceeds the limit exactly when the divide-based
   // cutoff test would flag it, so compare the widened sum instead.
   assign prod  = PROD_W'(acc_ff) * PROD_W'(take_radix) + PROD_W'(digit);
   assign limit = signed_mode_ff ? PROD_W'(neg_ff ? SIGNED_MIN : SIGNED_MAX)
                                 : PROD_W'(UNSIGNED_MAX);
   assign step_ovf = prod > limit;

   assign next_pos = (pos_ff < POS_LIMIT) ? pos_ff + POS_W'(1) : POS_LIMIT;

   // Next parse state for the current character.
   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      any_in   = any_ff;
      ovf_in   = ovf_ff;
      eff_in   = eff_ff;
      end_in   = end_ff;
      pos_in   = next_pos;
      unique case (phase_ff)
         PH_SPACE, PH_SIGNED: begin
            if (phase_ff == PH_SPACE && is_space(req_char_code)) begin
               phase_in = PH_SPACE;
            end else if (phase_ff == PH_SPACE &&
                         (req_char_code == CH_PLUS || req_char_code == CH_MINUS)) begin
               neg_in   = (req_char_code == CH_MINUS);
               phase_in = PH_SIGNED;
            end else begin
               eff_in   = take_radix;
               phase_in = !took ? PH_DONE : zero_prefix ? PH_ZERO : PH_DIGITS;
            end
         end
         PH_ZERO: begin
            if (!try_take) begin
               phase_in = PH_XSEEN;
            end else begin
               phase_in = took ? PH_DIGITS : PH_DONE;
            end
         end
         PH_XSEEN: begin
            // The prefix counts only when a hex digit follows it.
            if (took) begin
               eff_in = RADIX_HEX;
            end
            phase_in = took ? PH_DIGITS : PH_DONE;
         end
         PH_DIGITS: begin
            phase_in = took ? PH_DIGITS : PH_DONE;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
      if (took) begin
         any_in = 1'b1;
         end_in = next_pos;
         if (step_ovf) begin
            ovf_in = 1'b1;
         end else begin
            acc_in = prod[VALUE_W-1:0];
         end
      end
   end

   // Result of a string that closes on this character; negation is applied
   // at the output from the registered magnitude.
   always_comb begin
      value_in  = acc_in;
      negate_in = neg_ff;
      if (!any_in) begin
         value_in  = '0;
         negate_in = 1'b0;
      end else if (ovf_in) begin
         negate_in = 1'b0;
         if (signed_mode_ff) begin
            value_in = neg_ff ? SIGNED_MIN : SIGNED_MAX;
         end else begin
            value_in = UNSIGNED_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff       <= RESET_RADIX;
         signed_mode_ff <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RADIX:       radix_ff       <= csr_wdata;
            CSR_SIGNED_MODE: signed_mode_ff <= csr_wdata[0];
            default:         radix_ff       <= radix_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SPACE;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         any_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
         eff_ff   <= '0;
         pos_ff   <= '0;
         end_ff   <= '0;
      end else if (req_accept) begin
         if (req_last_char) begin
            // Start the next string from a clean state.
            phase_ff <= PH_SPACE;
            acc_ff   <= '0;
            neg_ff   <= 1'b0;
            any_ff   <= 1'b0;
            ovf_ff   <= 1'b0;
            eff_ff   <= '0;
            pos_ff   <= '0;
            end_ff   <= '0;
         end else begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            neg_ff   <= neg_in;
            any_ff   <= any_in;
            ovf_ff   <= ovf_in;
            eff_ff   <= eff_in;
            pos_ff   <= pos_in;
            end_ff   <= end_in;
         end
      end
   end

   // Result register: load on a last character, drop once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && req_last_char) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_last_char) begin
         value_ff  <= value_in;
         negate_ff <= negate_in;
         count_ff  <= any_in ? end_in : '0;
         digits_ff <= any_in;
         range_ff  <= any_in & ovf_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_parsed_value   = negate_ff ? (VALUE_W'(0) - value_ff) : value_ff;
   assign rsp_consumed_count = count_ff;
   assign rsp_digits_seen    = digits_ff;
   assign rsp_range_error    = range_ff;

   a_range_needs_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && range_ff |-> digits_ff)
      else $error("range error flagged on a result without digits");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !digits_ff |-> (count_ff == '0) && (rsp_parsed_value == '0))
      else $error("result without digits carries a value or count");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> count_ff <= POS_LIMIT)
      else $error("consumed count beyond the length limit");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_last_char |=> rsp_valid_ff && (phase_ff == PH_SPACE) &&
                                      (pos_ff == '0) && !any_ff)
      else $error("last character did not post a result and restart the parse");

endmodule

`default_nettype wire
